// ===== design/cbsf_pkg.sv =====
// cbsf_pkg: shared types, line codes and the byte-wide crc-32 update
// for the byte stuffing framer; no dependencies
`default_nettype none

package cbsf_pkg;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 32;
    localparam int CRC_BYTES   = CRC_W / BYTE_W;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CRC_W-1:0]  t_crc;

    localparam t_crc  CRC_POLY  = 32'hEDB8_8320;
    localparam t_crc  CRC_INIT  = 32'hFFFF_FFFF;
    localparam t_byte ESC_BYTE  = 8'h55;
    localparam t_byte TERM_BYTE = 8'hAA;
    localparam t_byte ESC_XOR   = 8'hF0;

    // one entry handed from the front to the back
    typedef struct packed {
        t_byte data;
        logic  last;
        t_crc  crc;     // final, inverted crc; meaningful only with last
    } t_cmd;

    // reflected crc-32, one byte, lsb first
    function automatic t_crc crc_byte(input t_crc acc, input t_byte data);
        t_crc c;
        c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/cbsf_in_if.sv =====
// cbsf_in_if: payload byte channel into the framer
// depends on cbsf_pkg
`default_nettype none

interface cbsf_in_if
    import cbsf_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== design/cbsf_out_if.sv =====
// cbsf_out_if: line byte channel out of the framer
// depends on cbsf_pkg
`default_nettype none

interface cbsf_out_if
    import cbsf_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/cbsf_front.sv =====
// cbsf_front: accepts payload bytes, keeps the running crc and builds
// queue entries; depends on cbsf_pkg and cbsf_in_if
`default_nettype none

module cbsf_front
    import cbsf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbsf_in_if.sink    i_in,
    output logic       o_push_valid,
    input  wire logic  i_push_ready,
    output t_cmd       o_push_cmd
);

    t_crc r_crc;
    t_crc n_crc;
    t_crc w_crc_upd;

    assign w_crc_upd = crc_byte(r_crc, i_in.data_byte);

    assign i_in.ready        = i_push_ready;
    assign o_push_valid      = i_in.valid;
    assign o_push_cmd.data   = i_in.data_byte;
    assign o_push_cmd.last   = i_in.last_byte;
    assign o_push_cmd.crc    = ~w_crc_upd;

    always_comb begin
        n_crc = r_crc;
        if (i_in.valid && i_push_ready) begin
            n_crc = i_in.last_byte ? CRC_INIT : w_crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule

`default_nettype wire

// ===== design/cbsf_queue.sv =====
// cbsf_queue: small register fifo of entries between front and back
// depends on cbsf_pkg
`default_nettype none

module cbsf_queue
    import cbsf_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH     // 2 or more
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_cmd,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_cmd      o_pop_cmd
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd            r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            w_push, w_pop;

    assign o_push_ready = (r_count != CW'(P_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/cbsf_back.sv =====
// cbsf_back: turns queue entries into stuffed line bytes, crc bytes and
// the terminator; depends on cbsf_pkg and cbsf_out_if
`default_nettype none

module cbsf_back
    import cbsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_pop_valid,
    output logic      o_pop_ready,
    input  wire t_cmd i_pop_cmd,
    cbsf_out_if.source o_out
);

    localparam int IW = $clog2(CRC_BYTES);

    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_CRC  = 3'b010,
        PH_TERM = 3'b100
    } t_phase;

    logic          r_busy,  n_busy;
    t_phase        r_phase, n_phase;
    logic          r_sub,   n_sub;      // second byte of an escape pair
    logic [IW-1:0] r_idx,   n_idx;
    t_cmd          r_cmd,   n_cmd;
    logic          r_out_valid, n_out_valid;
    t_byte         r_out_byte,  n_out_byte;
    logic          r_out_last,  n_out_last;

    logic  w_can_emit, w_step, w_special, w_unit_done, w_cmd_done, w_load;
    t_byte w_value, w_emit;

    assign w_can_emit = !r_out_valid || o_out.ready;
    assign w_step     = r_busy && w_can_emit;

    always_comb begin
        w_value     = r_cmd.data;
        w_special   = 1'b0;
        w_unit_done = 1'b1;
        w_cmd_done  = 1'b0;
        unique case (r_phase)
            PH_DATA: w_value = r_cmd.data;
            PH_CRC:  w_value = r_cmd.crc[r_idx*BYTE_W +: BYTE_W];
            PH_TERM: w_value = TERM_BYTE;
            default: w_value = r_cmd.data;
        endcase
        if (r_phase != PH_TERM) begin
            w_special = (w_value == TERM_BYTE) || (w_value == ESC_BYTE);
        end
        w_unit_done = r_sub || !w_special;
        w_cmd_done  = w_unit_done &&
                      (((r_phase == PH_DATA) && !r_cmd.last) || (r_phase == PH_TERM));
        if (r_sub) begin
            w_emit = w_value ^ ESC_XOR;
        end else if (w_special) begin
            w_emit = ESC_BYTE;
        end else begin
            w_emit = w_value;
        end
    end

    assign o_pop_ready = !r_busy || (w_step && w_cmd_done);
    assign w_load      = i_pop_valid && o_pop_ready;

    always_comb begin
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (w_can_emit) begin
            n_out_valid = w_step;
        end
        if (w_step) begin
            n_out_byte = w_emit;
            n_out_last = w_cmd_done;
            if (!w_unit_done) begin
                n_sub = 1'b1;
            end else begin
                n_sub = 1'b0;
                unique case (r_phase)
                    PH_DATA: begin
                        if (r_cmd.last) begin
                            n_phase = PH_CRC;
                            n_idx   = '0;
                        end else begin
                            n_busy = 1'b0;
                        end
                    end
                    PH_CRC: begin
                        if (r_idx == IW'(CRC_BYTES - 1)) begin
                            n_phase = PH_TERM;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    PH_TERM: n_busy = 1'b0;
                    default: n_busy = 1'b0;
                endcase
            end
        end
        if (w_load) begin
            n_busy  = 1'b1;
            n_phase = PH_DATA;
            n_sub   = 1'b0;
            n_idx   = '0;
            n_cmd   = i_pop_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_DATA;
            r_sub       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;

endmodule

`default_nettype wire

// ===== design/crc32_byte_stuffing_framer.sv =====
// crc32_byte_stuffing_framer: top level of the byte stuffing framer
// depends on cbsf_pkg, cbsf_in_if, cbsf_out_if, cbsf_front, cbsf_queue, cbsf_back
`default_nettype none

//  channel  dir  transaction           payload
//  i_in     in   one payload byte      data_byte[7:0], last_byte
//  o_out    out  one line byte         out_byte[7:0], last_of_run
//
//  the back end puts out one line byte per cycle while o_out is ready: a plain
//  byte gives 1 line byte, an escaped byte 2, a last byte 6 to 11 (escapes,
//  four crc bytes, terminator); the front takes one transaction per cycle while
//  the queue has room, so line bytes per transaction set the sustained rate;
//  output is registered; synchronous active-low reset empties the queue, drops
//  any pending output and sets the crc to all ones; either side may stall

module crc32_byte_stuffing_framer
    import cbsf_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbsf_in_if.sink    i_in,
    cbsf_out_if.source o_out
);

    // front to queue
    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;

    // queue to back
    logic w_pop_valid;
    logic w_pop_ready;
    t_cmd w_pop_cmd;

    // crc runs in the front, so the queue carries the finished crc with the
    // last byte and the next frame can start before the trailer is out
    cbsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    // decouples acceptance from the variable-length line output
    cbsf_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // stuffing sequencer with registered output stage
    cbsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_cmd   (w_pop_cmd),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking bench for crc32_byte_stuffing_framer, payload bytes in, line bytes out
// depends on cbsf_pkg, cbsf_in_if, cbsf_out_if and the framer rtl
`timescale 1ns / 100ps

module tb;
    import cbsf_pkg::*;

    localparam int  RANDOM_ITEMS = 235;
    localparam int  TAIL_ITEMS   = 40;     // no new idle bursts start once this few payload bytes remain
    localparam int  DRAIN_CYCLES = 24;
    localparam real TIMEOUT_NS   = 2_000_000.0;

    typedef struct packed {
        t_byte data_byte;
        logic  last_byte;
    } t_payload;

    typedef struct packed {
        t_byte out_byte;
        logic  last_of_run;
    } t_line_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    cbsf_in_if  in_ch ();
    cbsf_out_if out_ch ();

    crc32_byte_stuffing_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_payload   payload_q[$];     // payload bytes still to be driven
    t_line_byte line_q[$];        // line bytes the framer owes us, oldest first
    t_byte      run_bytes[$];     // scratch: line bytes of one payload transaction
    t_crc       frame_crc = CRC_INIT;

    int planned_items  = 0;
    int accepted_items = 0;
    int frames_closed  = 0;
    int checked_bytes  = 0;
    int escapes_seen   = 0;
    int mismatches     = 0;

    logic in_taken = 1'b0;
    int   src_gap  = 0;
    int   snk_gap  = 0;
    int   src_pct  = 0;
    int   snk_pct  = 0;
    int   pct_tick = 0;

    // ------------------------------------------------------------------
    // line byte predictor
    // ------------------------------------------------------------------

    // reflected crc-32, one data bit per step
    function automatic t_crc fcs_advance(t_crc acc, t_byte d);
        t_crc c;
        c = acc;
        for (int i = 0; i < BYTE_W; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0] ^ d[i]}});
        end
        return c;
    endfunction

    // escape the two reserved values, everything else goes out unchanged
    function automatic void stuff_byte(t_byte b);
        if (b == TERM_BYTE || b == ESC_BYTE) begin
            run_bytes.push_back(ESC_BYTE);
            run_bytes.push_back(b ^ ESC_XOR);
        end else begin
            run_bytes.push_back(b);
        end
    endfunction

    // expected line bytes for one accepted payload transaction
    function automatic void frame_payload(t_byte d, logic last);
        t_crc fcs;
        run_bytes.delete();
        frame_crc = fcs_advance(frame_crc, d);
        stuff_byte(d);
        if (last) begin
            fcs = ~frame_crc;
            for (int k = 0; k < CRC_BYTES; k++) begin
                stuff_byte(fcs[BYTE_W*k +: BYTE_W]);
            end
            run_bytes.push_back(TERM_BYTE);
            frame_crc = CRC_INIT;
            frames_closed++;
        end
        for (int i = 0; i < run_bytes.size(); i++) begin
            line_q.push_back('{run_bytes[i], i == run_bytes.size() - 1});
        end
    endfunction

    // a single-byte frame whose fcs holds the given value, or -1
    function automatic int find_crc_escape(t_byte target);
        t_crc fcs;
        for (int d = 0; d < 256; d++) begin
            fcs = ~fcs_advance(CRC_INIT, t_byte'(d));
            for (int k = 0; k < CRC_BYTES; k++) begin
                if (fcs[BYTE_W*k +: BYTE_W] == target) begin
                    return d;
                end
            end
        end
        return -1;
    endfunction

    function automatic void queue_payload(t_byte d, logic last);
        payload_q.push_back('{d, last});
        planned_items++;
    endfunction

    // ------------------------------------------------------------------
    // idling: each side re-picks its stall rate now and then, so that
    // stretches with no idling alternate with busy ones
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        pct_tick <= pct_tick + 1;
        if (pct_tick % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: src_pct <= 0;
                1: src_pct <= 15;
                default: src_pct <= 40;
            endcase
            case ($urandom_range(0, 2))
                0: snk_pct <= 0;
                1: snk_pct <= 15;
                default: snk_pct <= 40;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload driver: a new transaction once the previous one is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_payload nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (src_gap != 0) begin
                src_gap     <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (payload_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < src_pct) begin
                // start an idle burst
                src_gap     <= $urandom_range(0, 8);
                in_ch.valid <= 1'b0;
            end else if (payload_q.size() != 0) begin
                nxt             = payload_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= nxt.data_byte;
                in_ch.last_byte <= nxt.last_byte;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // line side back-pressure
    always @(negedge i_clk) begin
        if (snk_gap != 0) begin
            snk_gap      <= snk_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (payload_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < snk_pct) begin
            snk_gap      <= $urandom_range(0, 8);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on every payload transaction, check every line byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_byte want;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                frame_payload(in_ch.data_byte, in_ch.last_byte);
                accepted_items++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (line_q.size() == 0) begin
                    $error("unexpected line byte out_byte=%h last_of_run=%b",
                           out_ch.out_byte, out_ch.last_of_run);
                    mismatches++;
                end else begin
                    want = line_q.pop_front();
                    checked_bytes++;
                    if (want.out_byte == ESC_BYTE) begin
                        escapes_seen++;
                    end
                    if (out_ch.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_ch.out_byte);
                        mismatches++;
                    end
                    if (out_ch.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, out_ch.last_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int   hit;
        int   len;
        int   rnd_items;
        t_byte b;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;

        // one-byte frames at the extremes and on both reserved values
        queue_payload(8'h00, 1'b1);
        queue_payload(8'hFF, 1'b1);
        queue_payload(TERM_BYTE, 1'b1);
        queue_payload(ESC_BYTE, 1'b1);
        // a longer frame mixing reserved values with their near neighbors
        queue_payload(TERM_BYTE, 1'b0);
        queue_payload(ESC_BYTE, 1'b0);
        queue_payload(8'h00, 1'b0);
        queue_payload(8'hFF, 1'b0);
        queue_payload(8'h5A, 1'b0);
        queue_payload(8'hA5, 1'b0);
        queue_payload(8'hF0, 1'b0);
        queue_payload(8'h0F, 1'b0);
        queue_payload(ESC_BYTE ^ ESC_XOR, 1'b0);
        queue_payload(TERM_BYTE ^ ESC_XOR, 1'b1);
        // frames whose fcs carries a reserved value and so must be escaped
        hit = find_crc_escape(TERM_BYTE);
        if (hit >= 0) begin
            queue_payload(t_byte'(hit), 1'b1);
        end
        hit = find_crc_escape(ESC_BYTE);
        if (hit >= 0) begin
            queue_payload(t_byte'(hit), 1'b1);
        end

        // random frames, mostly short, reserved values favored
        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    b = $urandom_range(0, 1) ? ESC_BYTE : TERM_BYTE;
                end else begin
                    b = t_byte'($urandom_range(0, 255));
                end
                queue_payload(b, i == len - 1);
            end
            rnd_items += len;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items != planned_items || line_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("framer run: %0d payload bytes in %0d frames, %0d line bytes checked",
                 accepted_items, frames_closed, checked_bytes);
        $display("framer run: %0d escape sequences, %0d mismatches", escapes_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d of %0d payload bytes taken, %0d line bytes outstanding",
                 accepted_items, planned_items, line_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cbsf_pkg.sv
design/cbsf_in_if.sv
design/cbsf_out_if.sv
design/cbsf_front.sv
design/cbsf_queue.sv
design/cbsf_back.sv
design/crc32_byte_stuffing_framer.sv
test/tb.sv
